@@ hdl/lcg_with_permuted_output_assert.svh @@
// assertion macros for the lcg with permuted output block
// no dependencies; included by the rtl files that carry assertions
`ifndef LCG_WITH_PERMUTED_OUTPUT_ASSERT_SVH
`define LCG_WITH_PERMUTED_OUTPUT_ASSERT_SVH
`ifndef ASSERT_OFF
// check that is held off while reset is asserted
`define LCGPO_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// check that also runs during reset
`define LCGPO_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LCGPO_ASSERT(lbl, clk, rstn, prop, msg)
`define LCGPO_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ hdl/lcgpo_pkg.sv @@
// shared widths, constants and datapath opcodes for the lcg with permuted output block
// no dependencies
package lcgpo_pkg;

	localparam int unsigned MAX_ROUNDS = 16;
	localparam int unsigned ROUND_W    = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;

	localparam int unsigned SAMPLE_W = 10;
	localparam int unsigned VALUE_W  = 16;
	localparam int unsigned STATE_W  = 32;
	localparam int unsigned SHIFT_W  = 5;
	localparam int unsigned TOP_W    = 4;

	localparam logic [STATE_W-1:0] LCG_MUL  = 32'd1103515245;
	localparam logic [STATE_W-1:0] LCG_ADD  = 32'd12345;
	localparam logic [STATE_W-1:0] LCG_MASK = 32'h7FFF_FFFF;
	localparam logic [STATE_W-1:0] MIX_MUL  = 32'd277803737;
	localparam logic [STATE_W-1:0] OUT_MASK = 32'h0000_FFFF;
	localparam int unsigned MIX_SHIFT  = 22;
	localparam int unsigned TOP_SHIFT  = 28;
	localparam int unsigned BASE_SHIFT = 4;

	typedef enum logic [2:0] {
		OP_HOLD       = 3'd0,
		OP_LOAD_SEED  = 3'd1,
		OP_LOAD_STATE = 3'd2,
		OP_LCG        = 3'd3,
		OP_XS1        = 3'd4,
		OP_MUL        = 3'd5,
		OP_XS2        = 3'd6
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   commit;
	} dp_cmd_t;

endpackage

@@ hdl/lcgpo_if.sv @@
// valid/ready channel interfaces for the request and result transactions
// depends on lcgpo_pkg
interface lcgpo_req_if;
	logic                           valid;
	logic                           ready;
	logic                           kind;
	logic [lcgpo_pkg::SAMPLE_W-1:0] sample;

	modport source (output valid, output kind, output sample, input ready);
	modport sink (input valid, input kind, input sample, output ready);
endinterface

interface lcgpo_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [lcgpo_pkg::VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

@@ hdl/lcgpo_ctrl.sv @@
// controller state machine: sequences load, lcg rounds, output mix and commit
// depends on lcgpo_pkg and lcg_with_permuted_output_assert.svh
`include "lcg_with_permuted_output_assert.svh"

module lcgpo_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  logic                          req_kind,
	input  logic [lcgpo_pkg::ROUND_W-1:0] req_rounds,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output lcgpo_pkg::dp_cmd_t            cmd
);
	import lcgpo_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_LCG  = 6'b000010,
		ST_XS1  = 6'b000100,
		ST_MUL  = 6'b001000,
		ST_XS2  = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	state_t             st_q, st_d;
	logic [ROUND_W-1:0] cnt_q, cnt_d;
	logic               rsp_valid_q;
	logic               fire;

	assign req_ready = (st_q == ST_IDLE);
	assign fire      = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		st_d       = st_q;
		cnt_d      = cnt_q;
		cmd.op     = OP_HOLD;
		cmd.commit = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				if (fire) begin
					cnt_d = req_rounds;
					if (!req_kind) begin
						cmd.op = OP_LOAD_SEED;
						st_d   = ST_FIN;
					end else begin
						cmd.op = OP_LOAD_STATE;
						st_d   = (req_rounds != '0) ? ST_LCG : ST_XS1;
					end
				end
			end
			ST_LCG: begin
				cmd.op = OP_LCG;
				cnt_d  = cnt_q - 1'b1;
				if (cnt_q == ROUND_W'(1)) begin
					st_d = ST_XS1;
				end
			end
			ST_XS1: begin
				cmd.op = OP_XS1;
				st_d   = ST_MUL;
			end
			ST_MUL: begin
				cmd.op = OP_MUL;
				st_d   = ST_XS2;
			end
			ST_XS2: begin
				cmd.op = OP_XS2;
				st_d   = ST_FIN;
			end
			ST_FIN: begin
				// wait for the result register to free up
				if (!rsp_valid_q || rsp_ready) begin
					cmd.commit = 1'b1;
					st_d       = ST_IDLE;
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			st_q  <= st_d;
			cnt_q <= cnt_d;
			if (cmd.commit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	`LCGPO_ASSERT(a_lcg_cnt_live, clk, arst_n, (st_q == ST_LCG) |-> (cnt_q != '0), "lcg round with zero count")
	`LCGPO_ASSERT(a_seed_to_fin, clk, arst_n, (fire && !req_kind) |=> (st_q == ST_FIN), "seed did not go to commit")
	`LCGPO_ASSERT(a_commit_valid, clk, arst_n, cmd.commit |=> (rsp_valid_q && st_q == ST_IDLE), "commit did not raise result valid")
	`LCGPO_ASSERT_ALWAYS(a_rst_idle, clk, !arst_n |=> (st_q == ST_IDLE && !rsp_valid_q), "not idle in reset")

endmodule

@@ hdl/lcgpo_dp.sv @@
// datapath: working register, generator state, shared 32x32 multiplier, result register
// depends on lcgpo_pkg
module lcgpo_dp (
	input  logic                           clk,
	input  logic [lcgpo_pkg::SAMPLE_W-1:0] sample,
	input  lcgpo_pkg::dp_cmd_t             cmd,
	input  logic                           arst_n,
	output logic [lcgpo_pkg::VALUE_W-1:0]  value
);
	import lcgpo_pkg::*;

	logic [STATE_W-1:0] s_q;
	logic [STATE_W-1:0] gen_state_q;
	logic [VALUE_W-1:0] value_q;
	logic [STATE_W-1:0] mul_b;
	logic [STATE_W-1:0] prod;
	logic [TOP_W-1:0]   top_bits;
	logic [SHIFT_W-1:0] sh;

	// one multiplier shared by the lcg rounds and the output mix
	assign mul_b    = (cmd.op == OP_MUL) ? MIX_MUL : LCG_MUL;
	assign prod     = s_q * mul_b;
	assign top_bits = TOP_W'(s_q >> TOP_SHIFT);
	assign sh       = SHIFT_W'(BASE_SHIFT) + SHIFT_W'(top_bits);
	assign value    = value_q;

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_HOLD:       s_q <= s_q;
			OP_LOAD_SEED:  s_q <= STATE_W'(sample);
			OP_LOAD_STATE: s_q <= gen_state_q;
			OP_LCG:        s_q <= (prod + LCG_ADD) & LCG_MASK;
			OP_XS1:        s_q <= s_q ^ (s_q >> sh);
			OP_MUL:        s_q <= prod;
			OP_XS2:        s_q <= (s_q ^ (s_q >> MIX_SHIFT)) & OUT_MASK;
			default:       s_q <= s_q;
		endcase
		if (cmd.commit) begin
			value_q <= s_q[VALUE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_state_q <= '0;
		end else if (cmd.commit) begin
			gen_state_q <= s_q;
		end
	end

endmodule

@@ hdl/lcg_with_permuted_output.sv @@
// top level of the lcg with permuted output generator
// depends on lcgpo_pkg, lcgpo_if, lcgpo_ctrl and lcgpo_dp
//
//  channel | dir | transaction payload
//  --------+-----+------------------------------------------------
//  req     | in  | kind (1 = draw, 0 = seed), sample [9:0]
//  rsp     | out | value [15:0], drawn value or the loaded seed
//
// a seed transaction goes from accept straight to the commit step that raises result valid
// a draw first runs (sample mod MAX_ROUNDS) lcg rounds, then the output mix in
//   three steps through the one shared multiplier, and then the commit step;
//   req ready returns the cycle after commit
// one transaction at a time; the next is accepted as soon as the result is
//   committed, even while that result still waits in the output register
// a result stall holds the commit step until the output register frees up
// reset clears the generator state to zero and drops result valid
module lcg_with_permuted_output (
	input  logic        clk,
	input  logic        arst_n,
	lcgpo_req_if.sink   req,
	lcgpo_rsp_if.source rsp
);
	import lcgpo_pkg::*;

	dp_cmd_t            cmd;
	logic [ROUND_W-1:0] rounds;

	// step count from the one sample that travels with the draw
	assign rounds = ROUND_W'(req.sample % MAX_ROUNDS);

	// sequencer: owns the round counter and the result valid flag
	lcgpo_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req.valid),
		.req_ready  (req.ready),
		.req_kind   (req.kind),
		.req_rounds (rounds),
		.rsp_valid  (rsp.valid),
		.rsp_ready  (rsp.ready),
		.cmd        (cmd)
	);

	// datapath: working value, generator state and result register
	lcgpo_dp u_dp (
		.clk    (clk),
		.sample (req.sample),
		.cmd    (cmd),
		.arst_n (arst_n),
		.value  (rsp.value)
	);

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// self-checking bench for lcg_with_permuted_output: seed and draw transactions
// against a bit-true generator model, with random idling on both channels
// depends on lcgpo_pkg, lcgpo_if and the lcg_with_permuted_output rtl
module tb_top;
	import lcgpo_pkg::*;

	// request kinds as carried on req.kind
	typedef enum logic {
		KIND_SEED = 1'b0,
		KIND_DRAW = 1'b1
	} kind_t;

	// cycles with no transaction on either channel before the run is abandoned
	localparam int unsigned STALL_LIMIT = 4000;
	// quiet time after the drain, to catch any late stray result
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned RANDOM_PER_PHASE = 142;

	// generator model plus the queue of values still owed by the block
	class prng_scoreboard;
		logic [STATE_W-1:0] gen_state;
		logic [VALUE_W-1:0] pending_values[$];
		int                 errors;

		// constants of the generator, kept apart from the rtl copies
		localparam logic [31:0] STEP_MUL  = 32'd1103515245;
		localparam logic [31:0] STEP_ADD  = 32'd12345;
		localparam logic [31:0] STEP_MASK = 32'h7FFF_FFFF;
		localparam logic [31:0] PERM_MUL  = 32'd277803737;

		function new();
			gen_state = '0;
			errors    = 0;
		endfunction

		function logic [31:0] lcg_round(logic [31:0] s);
			logic [31:0] prod;
			prod = s * STEP_MUL;
			return (prod + STEP_ADD) & STEP_MASK;
		endfunction

		// xorshift by 4 plus top nibble, multiply, xorshift by 22, keep 16 bits
		function logic [31:0] permute(logic [31:0] s);
			int unsigned sh;
			sh = 4 + (s >> 28);
			s  = s ^ (s >> sh);
			s  = s * PERM_MUL;
			s  = s ^ (s >> 22);
			return s & 32'h0000_FFFF;
		endfunction

		function void note_request(kind_t k, logic [SAMPLE_W-1:0] sample);
			logic [31:0] s;
			int unsigned rounds;
			if (k == KIND_SEED) begin
				gen_state = {{(STATE_W-SAMPLE_W){1'b0}}, sample};
			end else begin
				rounds = sample % MAX_ROUNDS;
				s      = gen_state;
				for (int unsigned i = 0; i < rounds; i++)
					s = lcg_round(s);
				gen_state = permute(s);
			end
			pending_values.push_back(gen_state[VALUE_W-1:0]);
		endfunction

		function void check_value(logic [VALUE_W-1:0] value);
			logic [VALUE_W-1:0] want;
			if (pending_values.size() == 0) begin
				$error("value %0h arrived with no transaction outstanding", value);
				errors++;
				return;
			end
			want = pending_values.pop_front();
			if (value !== want) begin
				$error("value: expected %0h, actual %0h", want, value);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	lcgpo_req_if req_ch ();
	lcgpo_rsp_if rsp_ch ();

	lcg_with_permuted_output dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	prng_scoreboard sb = new();

	// idle chances in percent per cycle, changed between phases
	int unsigned src_idle;
	int unsigned snk_idle;
	int unsigned stall_cycles;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side: check every accepted transaction, then pick the next ready
	// at random; ready is sampled before the edge updates land, so the
	// check sees exactly what the block saw
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready)
				sb.check_value(rsp_ch.value);
			rsp_ch.ready <= ($urandom_range(0, 99) >= snk_idle);
		end else begin
			rsp_ch.ready <= 1'b0;
		end
	end

	// watchdog: a hung handshake on either side ends the run
	always @(posedge clk) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// one request transaction; valid is left high on return so that a
	// back-to-back request keeps it up without a low-high pair in one step
	task automatic send_request(kind_t k, logic [SAMPLE_W-1:0] sample);
		while ($urandom_range(0, 99) < src_idle) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid  <= 1'b1;
		req_ch.kind   <= k;
		req_ch.sample <= sample;
		do
			@(posedge clk);
		while (!req_ch.ready);
		sb.note_request(k, sample);
	endtask

	// mostly draws with full-range samples, seeds now and then to move the state
	task automatic random_requests(int unsigned count);
		kind_t k;
		for (int unsigned i = 0; i < count; i++) begin
			k = ($urandom_range(0, 99) < 15) ? KIND_SEED : KIND_DRAW;
			send_request(k, SAMPLE_W'($urandom_range(0, 1023)));
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		req_ch.valid  = 1'b0;
		req_ch.kind   = 1'b0;
		req_ch.sample = '0;
		src_idle      = 38;
		snk_idle      = 66;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: a draw straight out of reset permutes the zero state,
		// zero step counts with and without high sample bits, longest count
		send_request(KIND_DRAW, 10'd0);
		send_request(KIND_SEED, 10'd0);
		send_request(KIND_DRAW, 10'd0);
		send_request(KIND_SEED, 10'd1023);
		send_request(KIND_DRAW, 10'd1023);
		send_request(KIND_DRAW, 10'd16);
		// every step count once, upper sample bits varied so they are ignored
		for (int unsigned r = 0; r < MAX_ROUNDS; r++)
			send_request(KIND_DRAW, SAMPLE_W'(r + MAX_ROUNDS * ((r * 7) % 64)));
		send_request(KIND_SEED, 10'd512);
		send_request(KIND_DRAW, 10'd512);

		// first phase: slow sender against a slower receiver
		random_requests(RANDOM_PER_PHASE);

		// second phase: roles swapped
		src_idle = 66;
		snk_idle = 38;
		random_requests(RANDOM_PER_PHASE);

		// last phase: both sides at full rate
		src_idle = 0;
		snk_idle = 0;
		random_requests(RANDOM_PER_PHASE);
		req_ch.valid <= 1'b0;

		// drain, then leave room for anything the block should not send
		while (sb.pending_values.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
